/* hw/rtl/protected_memory_region_unit_assert.svh */
// Assertion macros for the RTL of the protected memory region unit.
// Each macro expects a clock named clk and an active-low reset named rst_n.
`ifndef PROTECTED_MEMORY_REGION_UNIT_ASSERT_SVH
`define PROTECTED_MEMORY_REGION_UNIT_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define PMR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define PMR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/pmr_pkg.sv */
`default_nettype none

package pmr_pkg;

  // Store geometry. The store is split into byte lanes by the low address bits,
  // so any access of up to LANES consecutive bytes touches each lane at most once.
  // STORE_BYTES must be a power of two and a multiple of LANES.
  localparam int STORE_BYTES = 4096;
  localparam int LANES       = 4;
  localparam int LANE_W      = $clog2(LANES);
  localparam int ROWS        = STORE_BYTES / LANES;
  localparam int ROW_W       = $clog2(ROWS);
  localparam int OFS_W       = ROW_W + LANE_W;
  localparam int NB_W        = LANE_W + 1;

  // Field widths.
  localparam int ADDR_W  = 32;
  localparam int DATA_W  = 32;
  localparam int SIZE_W  = 13;
  localparam int FUNC_W  = 2;
  localparam int WIDTH_W = 2;
  localparam int CHK_W   = ADDR_W + 2;

  // Access kinds.
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FETCH = 2'd2;

  // Access widths.
  localparam logic [WIDTH_W-1:0] WID_BYTE = 2'd0;
  localparam logic [WIDTH_W-1:0] WID_HALF = 2'd1;
  localparam logic [WIDTH_W-1:0] WID_WORD = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_READ  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WRITE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXEC  = 3'd4;

  // Store traffic: a read enable shared by all lanes, and per-lane row, write enable and write byte.
  typedef struct packed {
    logic                           re;
    logic [LANES-1:0]               we;
    logic [LANES-1:0][ROW_W-1:0]    row;
    logic [LANES-1:0][7:0]          wdata;
  } pmr_mem_req_t;

  typedef logic [LANES-1:0][7:0] pmr_lane_data_t;

endpackage

`default_nettype wire

/* hw/rtl/protected_memory_region_unit.sv */
`default_nettype none

// Channel   | Ports                                            | Handshake
// ----------+--------------------------------------------------+------------------------------
// input     | in_func, in_access_width, in_access_address,     | word taken when start && !busy
//           | in_write_data                                    |
// result    | out_read_data, out_fault, out_in_section         | out_valid high for one cycle
// config    | cfg_we, cfg_index, cfg_data                      | written when cfg_we is high
//
// A result is strobed once its word is taken and has passed check, store access,
// read capture and output register; busy is low again in the strobe cycle, so a new
// word is taken only once the last result is strobed. The byte store is four lane memories.
// After reset a clearing pass zeroes the store, one row of four bytes a cycle,
// with busy held high; configuration writes are taken meanwhile.
// The receiver cannot stall, so results never wait.

module protected_memory_region_unit (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                start,
  output logic                               busy,
  input  wire  [pmr_pkg::FUNC_W-1:0]         in_func,
  input  wire  [pmr_pkg::WIDTH_W-1:0]        in_access_width,
  input  wire  [pmr_pkg::ADDR_W-1:0]         in_access_address,
  input  wire  [pmr_pkg::DATA_W-1:0]         in_write_data,
  output logic                               out_valid,
  output logic [pmr_pkg::DATA_W-1:0]         out_read_data,
  output logic                               out_fault,
  output logic                               out_in_section,
  input  wire                                cfg_we,
  input  wire  [pmr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [pmr_pkg::DATA_W-1:0]         cfg_data
);
  import pmr_pkg::*;

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_CHECK  = 3'd2;
  localparam logic [2:0] ST_ACCESS = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [ROW_W-1:0]    clr_cnt_r, clr_cnt_nxt;

  logic [ADDR_W-1:0]   cfg_base_r;
  logic [SIZE_W-1:0]   cfg_size_r;
  logic                cfg_read_r, cfg_write_r, cfg_exec_r;

  logic [FUNC_W-1:0]   func_r;
  logic [WIDTH_W-1:0]  width_r;
  logic [ADDR_W-1:0]   addr_r;
  logic [DATA_W-1:0]   wdata_r;

  logic [CHK_W-1:0]    limit_r, limit_nxt;
  logic [CHK_W-1:0]    end_r, end_nxt;
  logic                below_r, below_nxt;
  logic [OFS_W-1:0]    ofs_r, ofs_nxt;
  logic [NB_W-1:0]     nbytes_r, nbytes_nxt;
  logic                early_fault_r, early_fault_nxt;
  logic [CHK_W-1:0]    eff_size;
  logic                perm_ok;
  logic                width_bad;

  logic                fault_r, fault_nxt;
  logic                inside_r, inside_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [DATA_W-1:0]   out_read_data_r, out_read_data_nxt;
  logic                out_fault_r, out_in_section_r;

  logic                accept;
  logic [LANE_W-1:0]   lo;
  logic [ROW_W-1:0]    row0;
  pmr_mem_req_t        req;
  pmr_lane_data_t      rd_data;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_base_r  <= '0;
      cfg_size_r  <= '0;
      cfg_read_r  <= 1'b0;
      cfg_write_r <= 1'b0;
      cfg_exec_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE:  cfg_base_r  <= cfg_data[ADDR_W-1:0];
        CFG_SIZE:  cfg_size_r  <= cfg_data[SIZE_W-1:0];
        CFG_READ:  cfg_read_r  <= cfg_data[0];
        CFG_WRITE: cfg_write_r <= cfg_data[0];
        CFG_EXEC:  cfg_exec_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer: clearing pass, then check, access and capture per word.
  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + ROW_W'(1);
        if (clr_cnt_r == ROW_W'(ROWS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK:  state_nxt = ST_ACCESS;
      ST_ACCESS: state_nxt = ST_FINISH;
      ST_FINISH: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
    end
  end

  // Capture the input word.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_func;
      width_r <= in_access_width;
      addr_r  <= in_access_address;
      wdata_r <= in_write_data;
    end
  end

  // Check stage: byte count, permission, region limit and access end.
  always_comb begin
    width_bad  = 1'b0;
    nbytes_nxt = NB_W'(0);
    case (width_r)
      WID_BYTE: nbytes_nxt = NB_W'(1);
      WID_HALF: nbytes_nxt = NB_W'(2);
      WID_WORD: nbytes_nxt = NB_W'(4);
      default:  width_bad  = 1'b1;
    endcase

    case (func_r)
      FUNC_READ:  perm_ok = cfg_read_r;
      FUNC_WRITE: perm_ok = cfg_write_r;
      FUNC_FETCH: perm_ok = cfg_exec_r && cfg_read_r && (width_r != WID_BYTE);
      default:    perm_ok = 1'b0;
    endcase

    if (CHK_W'(cfg_size_r) > CHK_W'(STORE_BYTES)) begin
      eff_size = CHK_W'(STORE_BYTES);
    end else begin
      eff_size = CHK_W'(cfg_size_r);
    end

    early_fault_nxt = width_bad || !perm_ok;
    limit_nxt       = CHK_W'(cfg_base_r) + eff_size;
    end_nxt         = CHK_W'(addr_r) + CHK_W'(nbytes_nxt);
    below_nxt       = addr_r < cfg_base_r;
    ofs_nxt         = OFS_W'(addr_r - cfg_base_r);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_CHECK) begin
      limit_r       <= limit_nxt;
      end_r         <= end_nxt;
      below_r       <= below_nxt;
      ofs_r         <= ofs_nxt;
      nbytes_r      <= nbytes_nxt;
      early_fault_r <= early_fault_nxt;
    end
  end

  // Access stage: final fault and region test, then lane addressing.
  assign lo   = ofs_r[LANE_W-1:0];
  assign row0 = ofs_r[OFS_W-1:LANE_W];

  always_comb begin
    logic [LANE_W-1:0] pos;
    logic [LANE_W-1:0] src;
    pos        = '0;
    src        = '0;
    fault_nxt  = early_fault_r || below_r || (end_r > limit_r);
    inside_nxt = !below_r && (CHK_W'(addr_r) < limit_r);

    req = '0;
    if (state_r == ST_CLEAR) begin
      req.we = '1;
      for (int b = 0; b < LANES; b++) begin
        req.row[b] = clr_cnt_r;
      end
    end else if (state_r == ST_ACCESS) begin
      req.re = !fault_nxt && (func_r != FUNC_WRITE);
      for (int b = 0; b < LANES; b++) begin
        // pos is the byte's place in the access; src picks its byte of the word.
        pos          = LANE_W'(b) - lo;
        src          = LANE_W'(nbytes_r - NB_W'(1)) - pos;
        req.row[b]   = row0 + ROW_W'(LANE_W'(b) < lo);
        req.wdata[b] = wdata_r[8*src +: 8];
        req.we[b]    = !fault_nxt && (func_r == FUNC_WRITE) && (NB_W'(pos) < nbytes_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_ACCESS) begin
      fault_r  <= fault_nxt;
      inside_r <= inside_nxt;
    end
  end

  pmr_store u_store (
    .clk     (clk),
    .req     (req),
    .rd_data (rd_data)
  );

  // Capture stage: assemble the big-endian value from the lanes.
  always_comb begin
    out_read_data_nxt = '0;
    if (!fault_r && (func_r != FUNC_WRITE)) begin
      for (int i = 0; i < LANES; i++) begin
        if (NB_W'(i) < nbytes_r) begin
          out_read_data_nxt = {out_read_data_nxt[DATA_W-9:0], rd_data[lo + LANE_W'(i)]};
        end
      end
    end
    out_valid_nxt = (state_r == ST_FINISH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH) begin
      out_read_data_r  <= out_read_data_nxt;
      out_fault_r      <= fault_r;
      out_in_section_r <= inside_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_read_data_r;
  assign out_fault      = out_fault_r;
  assign out_in_section = out_in_section_r;

  `include "protected_memory_region_unit_assert.svh"

  `PMR_ASSERT_NEXT(a_accept_to_check, accept, state_r == ST_CHECK, "accepted word did not enter check")
  `PMR_ASSERT_NOW(a_strobe_after_finish, out_valid_r, $past(state_r == ST_FINISH), "result strobe without capture")
  `PMR_ASSERT_NOW(a_fault_reads_zero, out_valid_r && out_fault_r, out_read_data_r == '0, "faulting access returned data")
  `PMR_ASSERT_NOW(a_store_write_legal, req.we != '0, (state_r == ST_CLEAR) || ((state_r == ST_ACCESS) && !fault_nxt && (func_r == FUNC_WRITE)), "store written outside a legal write")

endmodule

`default_nettype wire

/* hw/rtl/pmr_store.sv */
`default_nettype none

module pmr_store (
  input  wire                     clk,
  input  wire pmr_pkg::pmr_mem_req_t req,
  output pmr_pkg::pmr_lane_data_t rd_data
);
  import pmr_pkg::*;

  // One synchronous byte memory per lane, read data registered.
  for (genvar b = 0; b < LANES; b++) begin : g_lane
    logic [7:0] bank [ROWS];
    logic [7:0] q_r;

    always_ff @(posedge clk) begin
      if (req.we[b]) begin
        bank[req.row[b]] <= req.wdata[b];
      end
      if (req.re) begin
        q_r <= bank[req.row[b]];
      end
    end

    assign rd_data[b] = q_r;
  end

endmodule

`default_nettype wire
